/* rtl/mm4_pkg.sv */
// shared types and constants of the 4x4 fixed-point matrix multiplier
package mm4_pkg;

    localparam int INDEX_W     = 4;
    localparam int STEP_W      = 6;
    localparam int K_W         = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 4'd15;
    localparam logic [K_W-1:0]     K_FIRST    = 2'd0;
    localparam logic [K_W-1:0]     K_LAST     = 2'd3;
    localparam logic [STEP_W-1:0]  STEP_LAST  = 6'd63;

    typedef enum logic [0:0] {
        S_IDLE,
        S_MAC
    } back_state_t;

    // queued request tag
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               start;
    } mm4_tag_t;

    // control carried alongside the mac pipeline
    typedef struct packed {
        logic               valid;
        logic [K_W-1:0]     k;
        logic [INDEX_W-1:0] pos;
    } mm4_stage_t;

endpackage

/* rtl/mat4_multiply.sv */
// top level of the 4x4 fixed-point matrix multiplier
// Each request writes one column-major element of A and of B; the request with
// index 15 also starts C = A * B, and sixteen results follow in column-major
// order, rounded half up to the input format and clipped, with saturated set on
// a clipped element. A four-entry request queue decouples intake from the single
// shared multiply-accumulate unit, which does one product per cycle while no
// result is stalled. The back end loads one queued request at a time and takes no
// load while a product is issued; after the last issue, the last result passes
// through the store read, product, accumulator and result registers. A stalled
// result holds the whole multiply-accumulate pipeline. The queue keeps accepting
// up to four requests while a product is in progress.
module mat4_multiply
    import mm4_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [INDEX_W-1:0]           element_index,
    input  logic signed [DATA_WIDTH-1:0] left_element,
    input  logic signed [DATA_WIDTH-1:0] right_element,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [INDEX_W-1:0]           result_index,
    output logic signed [DATA_WIDTH-1:0] product_element,
    output logic                         saturated,
    output logic                         last
);

    logic                  q_valid;
    logic                  q_pop;
    mm4_tag_t              q_tag;
    logic [DATA_WIDTH-1:0] q_left;
    logic [DATA_WIDTH-1:0] q_right;

    mm4_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_index (element_index),
        .left_element  (left_element),
        .right_element (right_element),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_tag         (q_tag),
        .q_left        (q_left),
        .q_right       (q_right)
    );

    mm4_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_tag           (q_tag),
        .q_left          (q_left),
        .q_right         (q_right),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_index    (result_index),
        .product_element (product_element),
        .saturated       (saturated),
        .last            (last)
    );

endmodule

/* rtl/mm4_ram.sv */
// generic single-write, single-read ram with registered read
module mm4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mm4_front.sv */
// request intake: tags each request and queues it for the mac sequencer
module mm4_front
    import mm4_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [INDEX_W-1:0]           element_index,
    input  logic signed [DATA_WIDTH-1:0] left_element,
    input  logic signed [DATA_WIDTH-1:0] right_element,
    output logic                         q_valid,
    input  logic                         q_pop,
    output mm4_tag_t                     q_tag,
    output logic [DATA_WIDTH-1:0]        q_left,
    output logic [DATA_WIDTH-1:0]        q_right
);

    mm4_tag_t                q_tag_reg   [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0]   q_left_reg  [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0]   q_right_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]     count_reg, count_next;
    logic                    push, pop;
    mm4_tag_t                in_tag;

    assign in_stall  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign pop       = q_valid && q_pop;
    assign q_valid   = (count_reg != '0);
    assign q_tag     = q_tag_reg[rd_ptr_reg];
    assign q_left    = q_left_reg[rd_ptr_reg];
    assign q_right   = q_right_reg[rd_ptr_reg];

    always_comb
    begin
        in_tag.idx   = element_index;
        in_tag.start = (element_index == LAST_INDEX);
        wr_ptr_next  = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_tag_reg[wr_ptr_reg]   <= in_tag;
            q_left_reg[wr_ptr_reg]  <= left_element;
            q_right_reg[wr_ptr_reg] <= right_element;
        end
    end

`ifndef ASSERT_OFF
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone push");
`endif

endmodule

/* rtl/mm4_back.sv */
// store update, shared multiply-accumulate sequencer, rounding and result register
module mm4_back
    import mm4_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  mm4_tag_t                     q_tag,
    input  logic [DATA_WIDTH-1:0]        q_left,
    input  logic [DATA_WIDTH-1:0]        q_right,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [INDEX_W-1:0]           result_index,
    output logic signed [DATA_WIDTH-1:0] product_element,
    output logic                         saturated,
    output logic                         last
);

    localparam int PROD_W = 2 * DATA_WIDTH;
    // wide enough for the full sum and for the rounding constant
    localparam int ACC_W  = (2 * DATA_WIDTH + 2 > FRAC_BITS + 2) ?
        2 * DATA_WIDTH + 2 : FRAC_BITS + 2;
    localparam logic signed [ACC_W-1:0] ROUND_C = (FRAC_BITS > 0) ?
        (ACC_W'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : '0;
    localparam logic [DATA_WIDTH-1:0] MAX_C = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_C = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    back_state_t              state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    mm4_stage_t               s1_reg, s1_next;
    mm4_stage_t               s2_reg;
    mm4_stage_t               s3_reg, s3_next;
    logic                     out_valid_reg;
    logic                     advance;
    logic                     issue;
    logic [INDEX_W-1:0]       left_raddr, right_raddr;
    logic [DATA_WIDTH-1:0]    left_rd, right_rd;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;
    logic                     ovf_hi, ovf_lo;
    logic [DATA_WIDTH-1:0]    clipped;
    logic [INDEX_W-1:0]       index_reg;
    logic [DATA_WIDTH-1:0]    value_reg;
    logic                     sat_reg;
    logic                     last_reg;

    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign issue   = (state_reg == S_MAC) && advance;

    // A is read down row r at 4k+r, B down column c at 4c+k
    assign left_raddr  = {step_reg[1:0], step_reg[3:2]};
    assign right_raddr = {step_reg[5:4], step_reg[1:0]};

    mm4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(16)) u_left_store (
        .clk   (clk),
        .we    (q_pop),
        .waddr (q_tag.idx),
        .wdata (q_left),
        .re    (issue),
        .raddr (left_raddr),
        .rdata (left_rd)
    );

    mm4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(16)) u_right_store (
        .clk   (clk),
        .we    (q_pop),
        .waddr (q_tag.idx),
        .wdata (q_right),
        .re    (issue),
        .raddr (right_raddr),
        .rdata (right_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop && q_tag.start)
                begin
                    state_next = S_MAC;
                    step_next  = '0;
                end
            end
            S_MAC:
            begin
                if (advance)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_next.valid = issue;
        s1_next.k     = step_reg[1:0];
        s1_next.pos   = step_reg[5:2];
        s3_next.valid = s2_reg.valid && (s2_reg.k == K_LAST);
        s3_next.k     = s2_reg.k;
        s3_next.pos   = s2_reg.pos;
    end

    assign acc_sum = ((s2_reg.k == K_FIRST) ? ACC_W'(0) : acc_reg)
                   + ACC_W'(prod_reg);

    // round half up, then clip to the output range
    assign rounded = acc_reg + ROUND_C;
    assign shifted = rounded >>> FRAC_BITS;
    assign ovf_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-1:DATA_WIDTH-1]);
    assign ovf_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-1:DATA_WIDTH-1]);
    assign clipped = ovf_hi ? MAX_C : (ovf_lo ? MIN_C : shifted[DATA_WIDTH-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (advance)
            begin
                s1_reg        <= s1_next;
                s2_reg        <= s1_reg;
                s3_reg        <= s3_next;
                out_valid_reg <= s3_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= $signed(left_rd) * $signed(right_rd);
            if (s2_reg.valid)
            begin
                acc_reg <= acc_sum;
            end
            if (s3_reg.valid)
            begin
                index_reg <= s3_reg.pos;
                value_reg <= clipped;
                sat_reg   <= ovf_hi || ovf_lo;
                last_reg  <= (s3_reg.pos == LAST_INDEX);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_index    = index_reg;
    assign product_element = value_reg;
    assign saturated       = sat_reg;
    assign last            = last_reg;

`ifndef ASSERT_OFF
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && state_reg == S_MAC)
            |=> ($stable(step_reg) && $stable(s3_reg)))
        else $error("mac pipeline moved while result stalled");
    a_sum_done: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_reg.valid && s2_reg.k == K_LAST) |=> s3_reg.valid)
        else $error("fourth product did not close the sum");
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && step_reg == STEP_LAST) |=> (state_reg == S_IDLE))
        else $error("sequencer overran the last step");
`endif

endmodule
